FILE: hdl/huffman_code_bit_packer_assert.svh
// ---------------------------------------------------------------------------
// assertion macros for the huffman code bit packer
// ---------------------------------------------------------------------------
`ifndef HUFFMAN_CODE_BIT_PACKER_ASSERT_SVH
`define HUFFMAN_CODE_BIT_PACKER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define HCBP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hcbp same-cycle check failed");

// next-cycle implication, checked out of reset
`define HCBP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hcbp next-cycle check failed");

`endif

FILE: hdl/hcbp_pkg.sv
// ---------------------------------------------------------------------------
// hcbp_pkg
// types and constants shared by the huffman code bit packer
// ---------------------------------------------------------------------------
package hcbp_pkg;

	localparam int SYM_W       = 8;
	localparam int CODE_W      = 32;
	localparam int LEN_W       = 6;
	localparam int BYTE_W      = 8;
	localparam int CNT_W       = 3;
	localparam int TABLE_DEPTH = 256;
	localparam int MAX_RESULTS = 4;
	localparam int NRES_W      = 3;
	localparam int ENTRY_W     = LEN_W + CODE_W;

	localparam logic [1:0] FUNC_LOAD   = 2'd0;
	localparam logic [1:0] FUNC_ENCODE = 2'd1;
	localparam logic [1:0] FUNC_FINISH = 2'd2;

	typedef struct packed {
		logic [1:0]        func;
		logic [SYM_W-1:0]  symbol;
		logic [CODE_W-1:0] code_word;
		logic [LEN_W-1:0]  code_length;
	} cmd_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              is_count;
		logic              last;
	} pk_t;

endpackage

FILE: hdl/hcbp_ram.sv
// ---------------------------------------------------------------------------
// hcbp_ram
// generic single-write, single-read ram with registered read data
// ---------------------------------------------------------------------------
module hcbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hdl/huffman_code_bit_packer.sv
// an accepted item is read from the code table into stage one, whose result bytes are registered into the output buffer
// throughput: one item per cycle while each gives at most one byte and pk_ready
// stays high; an item giving more bytes (up to four) holds stage one until the
// one-byte result port is taking the last byte of the output buffer
// reset clears the bit accumulator and the pipeline; the code table is not cleared
// ---------------------------------------------------------------------------
// huffman_code_bit_packer
// table lookup of huffman codes and lsb-first packing of the code bits into bytes
// ---------------------------------------------------------------------------
module huffman_code_bit_packer #(
	parameter int MAX_CODE_BITS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  hcbp_pkg::cmd_t cmd,
	output logic          pk_valid,
	input  logic          pk_ready,
	output hcbp_pkg::pk_t pk
);

	import hcbp_pkg::*;

	`include "huffman_code_bit_packer_assert.svh"

	localparam int LenCap = (MAX_CODE_BITS < CODE_W) ? MAX_CODE_BITS : CODE_W;
	localparam int AccW   = CODE_W + BYTE_W;

	logic                 cmd_acc;
	logic                 valid_s1;
	logic [1:0]           func_s1;
	logic [ENTRY_W-1:0]   entry_rd;

	logic [BYTE_W-1:0]    pend_bits_q;
	logic [CNT_W-1:0]     pend_cnt_q;

	pk_t                  obuf_q [MAX_RESULTS];
	logic [NRES_W-1:0]    obuf_cnt_q;

	logic [LEN_W-1:0]     len_raw;
	logic [LEN_W-1:0]     len_eff;
	logic [CODE_W-1:0]    code_mask;
	logic [AccW-1:0]      acc;
	logic [LEN_W-1:0]     total;
	logic [NRES_W-1:0]    enc_nbytes;
	logic [BYTE_W-1:0]    enc_rem;
	logic [NRES_W-1:0]    s1_nres;
	pk_t                  new_res [MAX_RESULTS];
	logic                 obuf_free;
	logic                 s1_adv;
	logic                 pop;

	assign cmd_acc = cmd_valid && cmd_ready;

	hcbp_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (cmd_acc && (cmd.func == FUNC_LOAD)),
		.waddr(cmd.symbol),
		.wdata({cmd.code_length, cmd.code_word}),
		.re   (cmd_acc && (cmd.func == FUNC_ENCODE)),
		.raddr(cmd.symbol),
		.rdata(entry_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ready) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			func_s1 <= cmd.func;
		end
	end

	// effective length and masked code
	assign len_raw = entry_rd[ENTRY_W-1:CODE_W];
	assign len_eff = (len_raw > LEN_W'(LenCap)) ? LEN_W'(LenCap) : len_raw;

	always_comb begin
		for (int i = 0; i < CODE_W; i++) begin
			code_mask[i] = (LEN_W'(i) < len_eff);
		end
	end

	assign acc   = ({{BYTE_W{1'b0}}, entry_rd[CODE_W-1:0] & code_mask} << pend_cnt_q)
	             | {{CODE_W{1'b0}}, pend_bits_q};
	assign total = {{(LEN_W-CNT_W){1'b0}}, pend_cnt_q} + len_eff;
	assign enc_nbytes = total[LEN_W-1:CNT_W];

	always_comb begin
		unique case (enc_nbytes)
			3'd0:    enc_rem = acc[7:0];
			3'd1:    enc_rem = acc[15:8];
			3'd2:    enc_rem = acc[23:16];
			3'd3:    enc_rem = acc[31:24];
			default: enc_rem = acc[39:32];
		endcase
	end

	always_comb begin
		s1_nres = '0;
		for (int k = 0; k < MAX_RESULTS; k++) begin
			new_res[k].out_byte = acc[k*BYTE_W +: BYTE_W];
			new_res[k].is_count = 1'b0;
			new_res[k].last     = 1'b0;
		end
		unique case (func_s1)
			FUNC_ENCODE: begin
				s1_nres = enc_nbytes;
			end
			FUNC_FINISH: begin
				s1_nres = NRES_W'(2);
				new_res[0].out_byte = pend_bits_q;
				new_res[1].out_byte = {{(BYTE_W-CNT_W){1'b0}}, pend_cnt_q};
				new_res[1].is_count = 1'b1;
				new_res[1].last     = 1'b1;
			end
			default: begin
				s1_nres = '0;
			end
		endcase
	end

	// output buffer drains one byte a cycle while pk_ready; refilled when empty or as its last byte pops
	assign pop       = pk_valid && pk_ready;
	assign obuf_free = (obuf_cnt_q == '0) || ((obuf_cnt_q == NRES_W'(1)) && pk_ready);
	assign s1_adv    = valid_s1 && ((s1_nres == '0) || obuf_free);
	assign cmd_ready = !valid_s1 || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_bits_q <= '0;
			pend_cnt_q  <= '0;
		end else if (s1_adv) begin
			if (func_s1 == FUNC_ENCODE) begin
				pend_bits_q <= enc_rem;
				pend_cnt_q  <= total[CNT_W-1:0];
			end else if (func_s1 == FUNC_FINISH) begin
				pend_bits_q <= '0;
				pend_cnt_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obuf_cnt_q <= '0;
		end else if (s1_adv && (s1_nres != '0)) begin
			obuf_cnt_q <= s1_nres;
		end else if (pop) begin
			obuf_cnt_q <= obuf_cnt_q - NRES_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && (s1_nres != '0)) begin
			for (int k = 0; k < MAX_RESULTS; k++) begin
				obuf_q[k] <= new_res[k];
			end
		end else if (pop) begin
			for (int k = 0; k < MAX_RESULTS - 1; k++) begin
				obuf_q[k] <= obuf_q[k+1];
			end
		end
	end

	assign pk_valid = (obuf_cnt_q != '0);
	assign pk       = obuf_q[0];

	`HCBP_ASSERT_NOW(a_obuf_bound, clk, arst_n, 1'b1, obuf_cnt_q <= NRES_W'(MAX_RESULTS))
	`HCBP_ASSERT_NOW(a_last_is_count, clk, arst_n, pk_valid && pk.last, pk.is_count)
	`HCBP_ASSERT_NEXT(a_stall_holds, clk, arst_n, valid_s1 && !s1_adv,
		valid_s1 && $stable(func_s1))
	`HCBP_ASSERT_NEXT(a_finish_clears, clk, arst_n, s1_adv && (func_s1 == FUNC_FINISH),
		(pend_cnt_q == '0) && (pend_bits_q == '0))

endmodule
